### rtl/core/crsh_pkg.sv
// ---------------------------------------------------------------------------
// crsh_pkg: shared types and constants of the closest ray/segment hit unit
// Holds table sizing, field widths, opcodes, the controller states and the
// command and status bundles that join controller and datapath.
// ---------------------------------------------------------------------------
`default_nettype none

package crsh_pkg;

	localparam int MAX_SEGMENTS = 64;
	localparam int IDX_W        = $clog2(MAX_SEGMENTS);
	localparam int CNT_W        = 7;
	localparam int N_W          = (IDX_W + 1 > CNT_W) ? IDX_W + 1 : CNT_W;
	localparam int COORD_W      = 16;
	localparam int SEG_W        = 4 * COORD_W;
	localparam int PARAM_W      = 32;
	localparam int ADDR_W       = 3;
	localparam int DATA_W       = 32;

	localparam int DIV_N_W      = 64;
	localparam int DIV_D_W      = 36;
	localparam int DIV_Q_W      = 32;

	localparam logic OP_WRITE   = 1'b0;
	localparam logic OP_CAST    = 1'b1;

	localparam logic [ADDR_W-3:0] REG_SEGMENT_COUNT = '0;

	localparam logic DIV_SEL_T  = 1'b0;
	localparam logic DIV_SEL_P  = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_READ,
		ST_LOAD,
		ST_MULT,
		ST_COMB,
		ST_TEST,
		ST_TDIV,
		ST_NEXT,
		ST_XMUL,
		ST_XSTART,
		ST_XWAIT,
		ST_YMUL,
		ST_YSTART,
		ST_YWAIT,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic wr_seg;
		logic ld_cast;
		logic rd_seg;
		logic cap_sw;
		logic cap_prod;
		logic cap_comb;
		logic div_start;
		logic div_sel;
		logic upd_best;
		logic inc_idx;
		logic pt_mul;
		logic pt_axis;
		logic store_pt;
		logic ld_out;
	} cmd_t;

	typedef struct packed {
		logic cnt_zero;
		logic seg_hit;
		logic div_done;
		logic last_seg;
		logic found;
		logic out_free;
	} stat_t;

endpackage

`default_nettype wire

### rtl/core/closest_ray_segment_hit_unit.sv
// ---------------------------------------------------------------------------
// closest_ray_segment_hit_unit: closest ray/segment intersection engine
// Stores wall segments and, for each cast, reports the nearest segment that
// the ray hits, with hit point, ray parameter and segment index.
// ---------------------------------------------------------------------------
// A segment write produces no result.
// A cast tests the first segment_count entries, capped at the table size (none when
// segment_count is zero), and runs the divider, one bit a cycle, for each segment hit
// and twice more for the hit point when some segment was hit; one cast is in flight at a time.
// Reset clears the controller, the result valid and segment_count; table entries
// are undefined until written.
`default_nettype none

module closest_ray_segment_hit_unit import crsh_pkg::*; (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	// Configuration port.
	input  wire logic                      psel,
	input  wire logic                      penable,
	input  wire logic                      pwrite,
	input  wire logic [ADDR_W-1:0]         paddr,
	input  wire logic [DATA_W-1:0]         pwdata,
	output logic      [DATA_W-1:0]         prdata,
	output logic                           pready,
	// Input channel.
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire logic                      opcode,
	input  wire logic [IDX_W-1:0]          seg_index,
	input  wire logic signed [COORD_W-1:0] seg_ax,
	input  wire logic signed [COORD_W-1:0] seg_ay,
	input  wire logic signed [COORD_W-1:0] seg_bx,
	input  wire logic signed [COORD_W-1:0] seg_by,
	input  wire logic signed [COORD_W-1:0] ray_x,
	input  wire logic signed [COORD_W-1:0] ray_y,
	input  wire logic signed [COORD_W-1:0] ray_dx,
	input  wire logic signed [COORD_W-1:0] ray_dy,
	// Result channel.
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output logic                           hit,
	output logic signed [COORD_W-1:0]      hit_x,
	output logic signed [COORD_W-1:0]      hit_y,
	output logic [PARAM_W-1:0]             hit_param,
	output logic [IDX_W-1:0]               hit_segment
);

	// The single register sits at byte address zero; the word index is the
	// address above its byte offset bits.
	logic [CNT_W-1:0] seg_count_q;
	logic             reg_sel;
	cmd_t             cmd;
	stat_t            stat;
	state_t           state;

	assign pready  = 1'b1;
	assign reg_sel = (paddr[ADDR_W-1:2] == REG_SEGMENT_COUNT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_count_q <= '0;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			seg_count_q <= pwdata[CNT_W-1:0];
		end
	end

	assign prdata = reg_sel ? {{(DATA_W - CNT_W){1'b0}}, seg_count_q} : '0;

	// The controller accepts a transaction only when idle; a cast then walks the
	// table while the previous result may still wait in the output register.
	crsh_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.opcode  (opcode),
		.stat    (stat),
		.in_ready(in_ready),
		.cmd     (cmd),
		.state   (state)
	);

	crsh_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.wr_index   (seg_index),
		.seg_ax     (seg_ax),
		.seg_ay     (seg_ay),
		.seg_bx     (seg_bx),
		.seg_by     (seg_by),
		.ray_x      (ray_x),
		.ray_y      (ray_y),
		.ray_dx     (ray_dx),
		.ray_dy     (ray_dy),
		.seg_count  (seg_count_q),
		.out_ready  (out_ready),
		.out_valid  (out_valid),
		.hit        (hit),
		.hit_x      (hit_x),
		.hit_y      (hit_y),
		.hit_param  (hit_param),
		.hit_segment(hit_segment)
	);

	// A miss result carries all-zero fields.
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !hit) |-> ((hit_param == '0) && (hit_segment == '0) &&
			(hit_x == '0) && (hit_y == '0)))
		else $error("miss result with nonzero fields");

	// A cast transaction holds off the next transaction.
	a_cast_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && (opcode == OP_CAST)) |=> !in_ready)
		else $error("input accepted during a cast");

	// The result register is only loaded when it is free.
	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ld_out |-> (stat.out_free && (state == ST_FIN)))
		else $error("result overwritten before delivery");

endmodule

`default_nettype wire

### rtl/core/crsh_ram.sv
// ---------------------------------------------------------------------------
// crsh_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module crsh_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

### rtl/core/crsh_div.sv
// ---------------------------------------------------------------------------
// crsh_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle; saturates the quotient
// when it would not fit the quotient width.
// ---------------------------------------------------------------------------
`default_nettype none

module crsh_div import crsh_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [DIV_N_W-1:0] num,
	input  wire logic [DIV_D_W-1:0] den,
	output logic                    done,
	output logic                    sat,
	output logic      [DIV_Q_W-1:0] quo
);

	localparam int HI_W  = DIV_N_W - DIV_Q_W;
	localparam int CTR_W = $clog2(DIV_Q_W);

	logic               busy_q;
	logic               done_q;
	logic               sat_q;
	logic [CTR_W-1:0]   cnt_q;
	logic [DIV_D_W-1:0] rem_q;
	logic [DIV_D_W-1:0] den_q;
	logic [DIV_Q_W-1:0] low_q;
	logic [DIV_Q_W-1:0] quo_q;
	logic [DIV_D_W:0]   trial;
	logic [DIV_D_W:0]   diff;
	logic               ge;
	logic               start_sat;

	assign trial     = {rem_q, low_q[DIV_Q_W-1]};
	assign diff      = trial - {1'b0, den_q};
	assign ge        = trial >= {1'b0, den_q};
	// The quotient overflows exactly when the upper dividend half reaches the divisor.
	assign start_sat = {{(DIV_D_W - HI_W){1'b0}}, num[DIV_N_W-1:DIV_Q_W]} >= den;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= !start_sat;
				done_q <= start_sat;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CTR_W'(DIV_Q_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sat_q <= start_sat;
			den_q <= den;
			rem_q <= {{(DIV_D_W - HI_W){1'b0}}, num[DIV_N_W-1:DIV_Q_W]};
			low_q <= num[DIV_Q_W-1:0];
			quo_q <= start_sat ? '1 : '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
			low_q <= {low_q[DIV_Q_W-2:0], 1'b0};
			quo_q <= {quo_q[DIV_Q_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign sat  = sat_q;
	assign quo  = quo_q;

endmodule

`default_nettype wire

### rtl/core/crsh_datapath.sv
// ---------------------------------------------------------------------------
// crsh_datapath: segment table, intersection arithmetic and result registers
// Computes determinant and numerators per segment, keeps the closest hit,
// derives the hit point and holds the outgoing result.
// ---------------------------------------------------------------------------
`default_nettype none

module crsh_datapath import crsh_pkg::*; (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire cmd_t                      cmd,
	output stat_t                          stat,
	input  wire logic [IDX_W-1:0]          wr_index,
	input  wire logic signed [COORD_W-1:0] seg_ax,
	input  wire logic signed [COORD_W-1:0] seg_ay,
	input  wire logic signed [COORD_W-1:0] seg_bx,
	input  wire logic signed [COORD_W-1:0] seg_by,
	input  wire logic signed [COORD_W-1:0] ray_x,
	input  wire logic signed [COORD_W-1:0] ray_y,
	input  wire logic signed [COORD_W-1:0] ray_dx,
	input  wire logic signed [COORD_W-1:0] ray_dy,
	input  wire logic [CNT_W-1:0]          seg_count,
	input  wire logic                      out_ready,
	output logic                           out_valid,
	output logic                           hit,
	output logic signed [COORD_W-1:0]      hit_x,
	output logic signed [COORD_W-1:0]      hit_y,
	output logic [PARAM_W-1:0]             hit_param,
	output logic [IDX_W-1:0]               hit_segment
);

	function automatic logic signed [COORD_W-1:0] sat16(input logic signed [34:0] v);
		logic signed [COORD_W-1:0] r;
		if (v > 35'sd32767) begin
			r = 16'sh7FFF;
		end else if (v < -35'sd32768) begin
			r = 16'sh8000;
		end else begin
			r = v[COORD_W-1:0];
		end
		return r;
	endfunction

	// Cast operands and walk state.
	logic signed [COORD_W-1:0] rx_q, ry_q, dx_q, dy_q;
	logic [N_W-1:0]            n_q;
	logic [IDX_W-1:0]          idx_q;

	// Segment table.
	logic                      ram_we;
	logic [SEG_W-1:0]          ram_rdata;

	// Per-segment pipeline.
	logic signed [16:0]        sx_s1, sy_s1, wx_s1, wy_s1;
	logic signed [16:0]        dx17, dy17;
	logic signed [33:0]        pa_s2, pb_s2, pc_s2, pd_s2, pe_s2, pf_s2;
	logic signed [34:0]        det_c, nt_c, nu_c, det_n, nt_n, nu_n;
	logic                      hit_c;
	logic [33:0]               det_s3, nt_s3;
	logic                      hit_s3;

	// Closest hit so far.
	logic                      found_q;
	logic [PARAM_W-1:0]        best_t_q;
	logic [33:0]               best_nt_q, best_det_q;
	logic [IDX_W-1:0]          best_idx_q;

	// Hit point.
	logic signed [COORD_W-1:0] d_sel, r_sel;
	logic signed [50:0]        prod_s4;
	logic [49:0]               mag_c;
	logic [51:0]               np_lo;
	logic signed [34:0]        qs, qv, psum;
	logic signed [COORD_W-1:0] pt_val;
	logic signed [COORD_W-1:0] px_q, py_q;

	// Divider.
	logic [DIV_N_W-1:0]        div_num;
	logic [DIV_D_W-1:0]        div_den;
	logic                      div_done, div_sat;
	logic [DIV_Q_W-1:0]        div_quo;

	// Output register.
	logic                      out_valid_q;

	assign ram_we = cmd.wr_seg && (N_W'(wr_index) < N_W'(MAX_SEGMENTS));

	crsh_ram #(
		.WIDTH(SEG_W),
		.DEPTH(MAX_SEGMENTS)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(wr_index),
		.wdata({seg_ax, seg_ay, seg_bx, seg_by}),
		.re   (cmd.rd_seg),
		.raddr(idx_q),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q     <= '0;
			idx_q   <= '0;
			found_q <= 1'b0;
		end else begin
			if (cmd.ld_cast) begin
				n_q     <= (N_W'(seg_count) > N_W'(MAX_SEGMENTS)) ?
					N_W'(MAX_SEGMENTS) : N_W'(seg_count);
				idx_q   <= '0;
				found_q <= 1'b0;
			end else begin
				if (cmd.inc_idx) begin
					idx_q <= idx_q + 1'b1;
				end
				if (cmd.upd_best) begin
					found_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_cast) begin
			rx_q <= ray_x;
			ry_q <= ray_y;
			dx_q <= ray_dx;
			dy_q <= ray_dy;
		end
	end

	assign dx17 = {dx_q[COORD_W-1], dx_q};
	assign dy17 = {dy_q[COORD_W-1], dy_q};

	always_ff @(posedge clk) begin
		if (cmd.cap_sw) begin
			sx_s1 <= {ram_rdata[31], ram_rdata[31:16]} - {ram_rdata[63], ram_rdata[63:48]};
			sy_s1 <= {ram_rdata[15], ram_rdata[15:0]} - {ram_rdata[47], ram_rdata[47:32]};
			wx_s1 <= {ram_rdata[63], ram_rdata[63:48]} - {rx_q[COORD_W-1], rx_q};
			wy_s1 <= {ram_rdata[47], ram_rdata[47:32]} - {ry_q[COORD_W-1], ry_q};
		end
		if (cmd.cap_prod) begin
			pa_s2 <= sx_s1 * dy17;
			pb_s2 <= sy_s1 * dx17;
			pc_s2 <= sx_s1 * wy_s1;
			pd_s2 <= sy_s1 * wx_s1;
			pe_s2 <= dx17 * wy_s1;
			pf_s2 <= dy17 * wx_s1;
		end
		if (cmd.cap_comb) begin
			det_s3 <= det_n[33:0];
			nt_s3  <= nt_n[33:0];
			hit_s3 <= hit_c;
		end
	end

	assign det_c = pa_s2 - pb_s2;
	assign nt_c  = pc_s2 - pd_s2;
	assign nu_c  = pe_s2 - pf_s2;
	// A negative determinant flips all three so that the range tests read plainly.
	assign det_n = det_c[34] ? -det_c : det_c;
	assign nt_n  = det_c[34] ? -nt_c : nt_c;
	assign nu_n  = det_c[34] ? -nu_c : nu_c;
	assign hit_c = (det_c != '0) && !nt_n[34] && !nu_n[34] && (nu_n <= det_n);

	always_ff @(posedge clk) begin
		if (cmd.upd_best && (!found_q || (div_quo < best_t_q))) begin
			best_t_q   <= div_quo;
			best_nt_q  <= nt_s3;
			best_det_q <= det_s3;
			best_idx_q <= idx_q;
		end
	end

	assign d_sel = cmd.pt_axis ? dy_q : dx_q;
	assign r_sel = cmd.pt_axis ? ry_q : rx_q;

	always_ff @(posedge clk) begin
		if (cmd.pt_mul) begin
			prod_s4 <= d_sel * $signed({1'b0, best_nt_q});
		end
	end

	// Rounding to nearest, ties away from zero: (2*|p| + det) / (2*det).
	assign mag_c = prod_s4[50] ? 50'(-prod_s4) : prod_s4[49:0];
	assign np_lo = {1'b0, mag_c, 1'b0} + 52'(best_det_q);

	assign div_num = (cmd.div_sel == DIV_SEL_T) ? {4'b0, nt_s3, 26'b0} : {12'b0, np_lo};
	assign div_den = (cmd.div_sel == DIV_SEL_T) ? {2'b0, det_s3} : {1'b0, best_det_q, 1'b0};

	crsh_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.div_start),
		.num   (div_num),
		.den   (div_den),
		.done  (div_done),
		.sat   (div_sat),
		.quo   (div_quo)
	);

	assign qs     = $signed({3'b0, div_quo});
	assign qv     = prod_s4[50] ? -qs : qs;
	assign psum   = $signed({{19{r_sel[COORD_W-1]}}, r_sel}) + qv;
	assign pt_val = div_sat ? (prod_s4[50] ? 16'sh8000 : 16'sh7FFF) : sat16(psum);

	always_ff @(posedge clk) begin
		if (cmd.store_pt) begin
			if (cmd.pt_axis) begin
				py_q <= pt_val;
			end else begin
				px_q <= pt_val;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.ld_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_out) begin
			hit         <= found_q;
			hit_x       <= found_q ? px_q : '0;
			hit_y       <= found_q ? py_q : '0;
			hit_param   <= found_q ? best_t_q : '0;
			hit_segment <= found_q ? best_idx_q : '0;
		end
	end

	assign out_valid = out_valid_q;

	assign stat.cnt_zero = (seg_count == '0);
	assign stat.seg_hit  = hit_s3;
	assign stat.div_done = div_done;
	assign stat.last_seg = ((N_W'(idx_q) + 1'b1) == n_q);
	assign stat.found    = found_q;
	assign stat.out_free = !out_valid_q || out_ready;

endmodule

`default_nettype wire

### rtl/core/crsh_ctrl.sv
// ---------------------------------------------------------------------------
// crsh_ctrl: sequencer of the closest ray/segment hit unit
// Walks the segment table for each cast, drives the divider and the
// hit-point steps, and hands the result to the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module crsh_ctrl import crsh_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_valid,
	input  wire logic  opcode,
	input  wire stat_t stat,
	output logic       in_ready,
	output cmd_t       cmd,
	output state_t     state
);

	state_t state_q, state_d;
	logic   accept;

	assign accept = in_valid && (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && (opcode == OP_CAST)) begin
					state_d = stat.cnt_zero ? ST_FIN : ST_READ;
				end
			end
			ST_READ:   state_d = ST_LOAD;
			ST_LOAD:   state_d = ST_MULT;
			ST_MULT:   state_d = ST_COMB;
			ST_COMB:   state_d = ST_TEST;
			ST_TEST:   state_d = stat.seg_hit ? ST_TDIV : ST_NEXT;
			ST_TDIV: begin
				if (stat.div_done) begin
					state_d = ST_NEXT;
				end
			end
			ST_NEXT:   state_d = stat.last_seg ? ST_XMUL : ST_READ;
			ST_XMUL:   state_d = stat.found ? ST_XSTART : ST_FIN;
			ST_XSTART: state_d = ST_XWAIT;
			ST_XWAIT: begin
				if (stat.div_done) begin
					state_d = ST_YMUL;
				end
			end
			ST_YMUL:   state_d = ST_YSTART;
			ST_YSTART: state_d = ST_YWAIT;
			ST_YWAIT: begin
				if (stat.div_done) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (stat.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd          = '0;
		in_ready     = 1'b0;
		cmd.div_sel  = DIV_SEL_T;
		case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.wr_seg  = accept && (opcode == OP_WRITE);
				cmd.ld_cast = accept && (opcode == OP_CAST);
			end
			ST_READ:   cmd.rd_seg   = 1'b1;
			ST_LOAD:   cmd.cap_sw   = 1'b1;
			ST_MULT:   cmd.cap_prod = 1'b1;
			ST_COMB:   cmd.cap_comb = 1'b1;
			ST_TEST:   cmd.div_start = stat.seg_hit;
			ST_TDIV:   cmd.upd_best  = stat.div_done;
			ST_NEXT:   cmd.inc_idx   = !stat.last_seg;
			ST_XMUL:   cmd.pt_mul    = 1'b1;
			ST_XSTART: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DIV_SEL_P;
			end
			ST_XWAIT: begin
				cmd.div_sel  = DIV_SEL_P;
				cmd.store_pt = stat.div_done;
			end
			ST_YMUL: begin
				cmd.pt_mul  = 1'b1;
				cmd.pt_axis = 1'b1;
			end
			ST_YSTART: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DIV_SEL_P;
				cmd.pt_axis   = 1'b1;
			end
			ST_YWAIT: begin
				cmd.div_sel  = DIV_SEL_P;
				cmd.pt_axis  = 1'b1;
				cmd.store_pt = stat.div_done;
			end
			ST_FIN:    cmd.ld_out = stat.out_free;
			default: begin
				cmd = '0;
			end
		endcase
	end

	assign state = state_q;

endmodule

`default_nettype wire
